// ===== hdl/bcsa_pkg.sv =====
// shared types, constants and helper functions for the slot allocator
`default_nettype none
package bcsa_pkg;

	localparam int NUM_CHUNKS      = 16;
	localparam int CHUNK_BITS      = 4;
	localparam int WORDS_PER_CHUNK = 8;
	localparam int WORD_SEL_BITS   = 3;
	localparam int MAP_WORD_BITS   = 32;
	localparam int MAP_DEPTH       = NUM_CHUNKS * WORDS_PER_CHUNK;
	localparam int MAP_ADDR_BITS   = CHUNK_BITS + WORD_SEL_BITS;

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_DRAIN   = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EXHAUSTED = 3'd1;
	localparam logic [2:0] ST_RANGE     = 3'd2;
	localparam logic [2:0] ST_MISALIGN  = 3'd3;
	localparam logic [2:0] ST_DOUBLE    = 3'd4;

	localparam logic [1:0] REG_SLOT_BYTES  = 2'd0;
	localparam logic [1:0] REG_CHUNK_ITEMS = 2'd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_WREAD,
		S_WCHK,
		S_AMUL,
		S_SPAN,
		S_LIMIT,
		S_RANGE,
		S_DIVC,
		S_DIVS,
		S_RREAD,
		S_RCHK,
		S_DONE
	} bcsa_state_t;

	typedef struct packed {
		logic                     rd_en;
		logic [MAP_ADDR_BITS-1:0] rd_addr;
		logic                     wr_en;
		logic [MAP_ADDR_BITS-1:0] wr_addr;
		logic [MAP_WORD_BITS-1:0] wr_data;
		logic                     clr_all;
		logic                     clr_chunk_en;
		logic [CHUNK_BITS-1:0]    clr_chunk;
	} bcsa_map_ctl_t;

	function automatic logic [8:0] items_of(input logic [8:0] ci);
		logic [8:0] n;
		n = {ci[8:5], 5'b0};
		if (n < 9'd32) begin
			n = 9'd32;
		end
		if (n > 9'd256) begin
			n = 9'd256;
		end
		return n;
	endfunction

	function automatic logic [15:0] bytes_of(input logic [15:0] sb);
		return (sb == 16'd0) ? 16'd1 : sb;
	endfunction

	function automatic logic [4:0] lowest_set(input logic [MAP_WORD_BITS-1:0] w);
		logic [4:0] r;
		r = '0;
		for (int k = MAP_WORD_BITS - 1; k >= 0; k--) begin
			if (w[k]) begin
				r = 5'(k);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/bcsa_free_map.sv =====
// free bitmap memory with per-word valid bits and registered read
`default_nettype none
module bcsa_free_map (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire bcsa_pkg::bcsa_map_ctl_t                ctl,
	output logic [bcsa_pkg::MAP_WORD_BITS-1:0]          rd_word
);

	logic [bcsa_pkg::MAP_WORD_BITS-1:0] mem [bcsa_pkg::MAP_DEPTH];
	logic [bcsa_pkg::MAP_DEPTH-1:0]     vld_q;
	logic [bcsa_pkg::MAP_WORD_BITS-1:0] rd_data_q;
	logic                               rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= ctl.wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[ctl.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.clr_all) begin
				vld_q <= '0;
			end else begin
				if (ctl.clr_chunk_en) begin
					vld_q[{ctl.clr_chunk, {bcsa_pkg::WORD_SEL_BITS{1'b0}}}
						+: bcsa_pkg::WORDS_PER_CHUNK] <= '0;
				end
				if (ctl.wr_en) begin
					vld_q[ctl.wr_addr] <= 1'b1;
				end
			end
			if (ctl.rd_en) begin
				rd_vld_q <= vld_q[ctl.rd_addr];
			end
		end
	end

	// unwritten words read as all free
	assign rd_word = rd_vld_q ? rd_data_q : '1;

endmodule
`default_nettype wire

// ===== hdl/bitmap_chunked_slot_allocator_core.sv =====
// top level of the bitmap chunked slot allocator
// Usage: requests enter on req_valid/req_stall with opcode and address; each
// request gives one response transaction on rsp_valid/rsp_stall carrying
// status, slot_address, chunk_index and slot_index. Registers slot_bytes
// (index 0) and chunk_items (index 1) are written on cfg_valid/cfg_ready;
// either write empties the pool, as a drain request does.
// One request at a time passes through a small sequencer around a shared
// multiplier and a shared subtractor. Allocate scans the chunks in use (up
// to 16), opening a new chunk when none has room, then reads bitmap words
// of that chunk (up to 8) and clears the first free bit found. Release runs
// two multiplies, a range compare, a 4-step chunk division, an 8-step slot
// division and a bitmap read-modify-write; an out of range release ends
// after the compare and a misaligned one after the slot division. Drain and
// unused opcodes go straight to the response.
// Reset: slot_bytes 16, chunk_items 256, no active chunks, every slot free.
// The bitmap is cleared through per-word valid bits, so no clearing pass runs.
// A finished response waits in the output register while the next request
// is accepted; if rsp_stall holds it, the sequencer waits in its last state.
`default_nettype none
module bitmap_chunked_slot_allocator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] address,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [2:0]       status,
	output logic [31:0]      slot_address,
	output logic [3:0]       chunk_index,
	output logic [7:0]       slot_index,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	bcsa_pkg::bcsa_state_t   state_q, state_d;
	bcsa_pkg::bcsa_map_ctl_t map_ctl;
	logic [31:0]             map_word;

	logic [15:0] slot_bytes_q;
	logic [8:0]  chunk_items_q;
	logic [4:0]  active_q;
	logic [8:0]  occ_q [bcsa_pkg::NUM_CHUNKS];

	logic [31:0] addr_q;
	logic [4:0]  scan_q;
	logic [3:0]  c_q;
	logic [2:0]  w_q;
	logic [7:0]  i_q;
	logic        open_q;
	logic [11:0] base_q;
	logic [31:0] word_q;
	logic [27:0] prod_q;
	logic [23:0] span_q;
	logic [27:0] rem_q;
	logic [27:0] div_q;
	logic [7:0]  quo_q;
	logic [2:0]  cnt_q;

	logic [2:0]  res_status_q;
	logic [31:0] res_addr_q;
	logic [3:0]  res_chunk_q;
	logic [7:0]  res_slot_q;
	logic        rsp_valid_q;
	logic [2:0]  rsp_status_q;
	logic [31:0] rsp_addr_q;
	logic [3:0]  rsp_chunk_q;
	logic [7:0]  rsp_slot_q;

	logic [8:0]  items;
	logic [15:0] bytes;
	logic [3:0]  words;
	logic [8:0]  occ_cur;
	logic        req_take;
	logic        cfg_take;
	logic        pool_clr;
	logic        rsp_load;
	logic [23:0] mul_a;
	logic [15:0] mul_b;
	logic [39:0] mul_p;
	logic [28:0] diff;
	logic        ge;
	logic [27:0] rem_next;
	logic [4:0]  low_bit;
	logic        scan_in_active;

	assign items    = bcsa_pkg::items_of(chunk_items_q);
	assign bytes    = bcsa_pkg::bytes_of(slot_bytes_q);
	assign words    = items[8:5];
	assign occ_cur  = occ_q[scan_q[3:0]];
	assign low_bit  = bcsa_pkg::lowest_set(map_word);
	assign scan_in_active = (scan_q < active_q);

	assign req_stall = (state_q != bcsa_pkg::S_IDLE);
	assign cfg_ready = (state_q == bcsa_pkg::S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign cfg_take  = cfg_valid && cfg_ready;
	assign pool_clr  = (req_take && (opcode == bcsa_pkg::OP_DRAIN))
		|| (cfg_take && ((cfg_index == bcsa_pkg::REG_SLOT_BYTES)
		|| (cfg_index == bcsa_pkg::REG_CHUNK_ITEMS)));
	assign rsp_load  = (state_q == bcsa_pkg::S_DONE) && (!rsp_valid_q || !rsp_stall);

	// shared multiplier
	always_comb begin
		unique case (state_q)
			bcsa_pkg::S_SPAN: begin
				mul_a = {15'b0, items};
				mul_b = bytes;
			end
			bcsa_pkg::S_LIMIT: begin
				mul_a = prod_q[23:0];
				mul_b = {11'b0, active_q};
			end
			default: begin
				mul_a = {12'b0, base_q};
				mul_b = bytes;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// shared restoring division step
	assign diff     = {1'b0, rem_q} - {1'b0, div_q};
	assign ge       = !diff[28];
	assign rem_next = ge ? diff[27:0] : rem_q;

	bcsa_free_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (map_ctl),
		.rd_word (map_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcsa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		map_ctl = '0;
		map_ctl.clr_all = pool_clr;
		unique case (state_q)
			bcsa_pkg::S_IDLE: begin
				if (req_take) begin
					case (opcode)
						bcsa_pkg::OP_ALLOC:   state_d = bcsa_pkg::S_SCAN;
						bcsa_pkg::OP_RELEASE: state_d = bcsa_pkg::S_SPAN;
						default:              state_d = bcsa_pkg::S_DONE;
					endcase
				end
			end
			bcsa_pkg::S_SCAN: begin
				if (scan_in_active) begin
					if (occ_cur < items) begin
						state_d = bcsa_pkg::S_WREAD;
					end
				end else if (active_q < 5'(bcsa_pkg::NUM_CHUNKS)) begin
					state_d = bcsa_pkg::S_WREAD;
					map_ctl.clr_chunk_en = 1'b1;
					map_ctl.clr_chunk = active_q[3:0];
				end else begin
					state_d = bcsa_pkg::S_DONE;
				end
			end
			bcsa_pkg::S_WREAD: begin
				map_ctl.rd_en = 1'b1;
				map_ctl.rd_addr = {c_q, w_q};
				state_d = bcsa_pkg::S_WCHK;
			end
			bcsa_pkg::S_WCHK: begin
				if (map_word != '0) begin
					state_d = bcsa_pkg::S_AMUL;
				end else if (({1'b0, w_q} + 4'd1) >= words) begin
					state_d = bcsa_pkg::S_DONE;
				end else begin
					state_d = bcsa_pkg::S_WREAD;
				end
			end
			bcsa_pkg::S_AMUL: begin
				map_ctl.wr_en = 1'b1;
				map_ctl.wr_addr = {c_q, i_q[7:5]};
				map_ctl.wr_data = word_q & ~(32'd1 << i_q[4:0]);
				state_d = bcsa_pkg::S_DONE;
			end
			bcsa_pkg::S_SPAN: begin
				state_d = bcsa_pkg::S_LIMIT;
			end
			bcsa_pkg::S_LIMIT: begin
				state_d = bcsa_pkg::S_RANGE;
			end
			bcsa_pkg::S_RANGE: begin
				if (addr_q >= {4'b0, prod_q}) begin
					state_d = bcsa_pkg::S_DONE;
				end else begin
					state_d = bcsa_pkg::S_DIVC;
				end
			end
			bcsa_pkg::S_DIVC: begin
				if (cnt_q == 3'd0) begin
					state_d = bcsa_pkg::S_DIVS;
				end
			end
			bcsa_pkg::S_DIVS: begin
				if (cnt_q == 3'd0) begin
					if (rem_next != '0) begin
						state_d = bcsa_pkg::S_DONE;
					end else begin
						state_d = bcsa_pkg::S_RREAD;
					end
				end
			end
			bcsa_pkg::S_RREAD: begin
				map_ctl.rd_en = 1'b1;
				map_ctl.rd_addr = {c_q, i_q[7:5]};
				state_d = bcsa_pkg::S_RCHK;
			end
			bcsa_pkg::S_RCHK: begin
				if (!map_word[i_q[4:0]]) begin
					map_ctl.wr_en = 1'b1;
					map_ctl.wr_addr = {c_q, i_q[7:5]};
					map_ctl.wr_data = map_word | (32'd1 << i_q[4:0]);
				end
				state_d = bcsa_pkg::S_DONE;
			end
			bcsa_pkg::S_DONE: begin
				if (rsp_load) begin
					state_d = bcsa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bcsa_pkg::S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_q  <= 16'd16;
			chunk_items_q <= 9'd256;
			active_q      <= '0;
			rsp_valid_q   <= 1'b0;
			for (int k = 0; k < bcsa_pkg::NUM_CHUNKS; k++) begin
				occ_q[k] <= '0;
			end
		end else begin
			if (cfg_take) begin
				case (cfg_index)
					bcsa_pkg::REG_SLOT_BYTES:  slot_bytes_q <= cfg_data;
					bcsa_pkg::REG_CHUNK_ITEMS: chunk_items_q <= cfg_data[8:0];
					default: ;
				endcase
			end
			if (pool_clr) begin
				active_q <= '0;
				for (int k = 0; k < bcsa_pkg::NUM_CHUNKS; k++) begin
					occ_q[k] <= '0;
				end
			end
			if (state_q == bcsa_pkg::S_SCAN && !scan_in_active
				&& active_q < 5'(bcsa_pkg::NUM_CHUNKS)) begin
				occ_q[active_q[3:0]] <= '0;
			end
			if (state_q == bcsa_pkg::S_AMUL) begin
				occ_q[c_q] <= occ_q[c_q] + 9'd1;
				if (open_q) begin
					active_q <= active_q + 5'd1;
				end
			end
			if (state_q == bcsa_pkg::S_RCHK && !map_word[i_q[4:0]]
				&& occ_q[c_q] != '0) begin
				occ_q[c_q] <= occ_q[c_q] - 9'd1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			bcsa_pkg::S_IDLE: begin
				if (req_take) begin
					addr_q       <= address;
					scan_q       <= '0;
					res_status_q <= bcsa_pkg::ST_OK;
					res_addr_q   <= '0;
					res_chunk_q  <= '0;
					res_slot_q   <= '0;
				end
			end
			bcsa_pkg::S_SCAN: begin
				w_q <= '0;
				if (scan_in_active) begin
					c_q    <= scan_q[3:0];
					open_q <= 1'b0;
					scan_q <= scan_q + 5'd1;
				end else if (active_q < 5'(bcsa_pkg::NUM_CHUNKS)) begin
					c_q    <= active_q[3:0];
					open_q <= 1'b1;
				end else begin
					res_status_q <= bcsa_pkg::ST_EXHAUSTED;
				end
			end
			bcsa_pkg::S_WCHK: begin
				word_q <= map_word;
				i_q    <= {w_q, low_bit};
				base_q <= ({8'b0, c_q} * {3'b0, items}) + {4'b0, w_q, low_bit};
				w_q    <= w_q + 3'd1;
				if (map_word == '0 && ({1'b0, w_q} + 4'd1) >= words) begin
					res_status_q <= bcsa_pkg::ST_EXHAUSTED;
				end
			end
			bcsa_pkg::S_AMUL: begin
				res_addr_q  <= mul_p[31:0];
				res_chunk_q <= c_q;
				res_slot_q  <= i_q;
			end
			bcsa_pkg::S_SPAN: begin
				prod_q <= mul_p[27:0];
			end
			bcsa_pkg::S_LIMIT: begin
				span_q <= prod_q[23:0];
				prod_q <= mul_p[27:0];
			end
			bcsa_pkg::S_RANGE: begin
				rem_q <= addr_q[27:0];
				div_q <= {1'b0, span_q, 3'b0};
				cnt_q <= 3'd3;
				quo_q <= '0;
				if (addr_q >= {4'b0, prod_q}) begin
					res_status_q <= bcsa_pkg::ST_RANGE;
				end
			end
			bcsa_pkg::S_DIVC: begin
				rem_q <= rem_next;
				if (cnt_q == 3'd0) begin
					c_q   <= {quo_q[2:0], ge};
					div_q <= {5'b0, bytes, 7'b0};
					cnt_q <= 3'd7;
					quo_q <= '0;
				end else begin
					quo_q <= {quo_q[6:0], ge};
					div_q <= div_q >> 1;
					cnt_q <= cnt_q - 3'd1;
				end
			end
			bcsa_pkg::S_DIVS: begin
				rem_q <= rem_next;
				quo_q <= {quo_q[6:0], ge};
				div_q <= div_q >> 1;
				cnt_q <= cnt_q - 3'd1;
				if (cnt_q == 3'd0) begin
					i_q <= {quo_q[6:0], ge};
					if (rem_next != '0) begin
						res_status_q <= bcsa_pkg::ST_MISALIGN;
					end
				end
			end
			bcsa_pkg::S_RCHK: begin
				res_chunk_q <= c_q;
				res_slot_q  <= i_q;
				if (map_word[i_q[4:0]]) begin
					res_status_q <= bcsa_pkg::ST_DOUBLE;
				end
			end
			bcsa_pkg::S_DONE: begin
				if (rsp_load) begin
					rsp_status_q <= res_status_q;
					rsp_addr_q   <= res_addr_q;
					rsp_chunk_q  <= res_chunk_q;
					rsp_slot_q   <= res_slot_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = rsp_status_q;
	assign slot_address = rsp_addr_q;
	assign chunk_index  = rsp_chunk_q;
	assign slot_index   = rsp_slot_q;

endmodule
`default_nettype wire
